[src/srhe_pkg.sv]
package srhe_pkg;

   // Line buffer geometry
   localparam int LINE_BYTES_DEF = 16;
   localparam int LINE_DEPTH     = 16;
   localparam int FILL_W         = 5;

   // ASCII characters used in record text
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_1    = 8'h31;
   localparam logic [7:0] CHAR_5    = 8'h35;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_NL   = 8'h0A;

   // Fixed record bytes
   localparam logic [7:0] HDR_SUM   = 8'h2A;
   localparam logic [7:0] S5_COUNT  = 8'h03;
   localparam logic [7:0] S9_COUNT  = 8'h03;
   localparam logic [7:0] S9_SUM    = 8'hFC;
   localparam logic [7:0] S1_EXTRA  = 8'h03;

   // Pair positions inside the fixed records
   localparam logic [FILL_W-1:0] HDR_SUM_POS = 5'd16;
   localparam logic [FILL_W-1:0] HDR_NL_POS  = 5'd17;
   localparam logic [FILL_W-1:0] S5_NL_POS   = 5'd5;
   localparam logic [FILL_W-1:0] S9_LAST_POS = 5'd4;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] char_first;
      logic [7:0] char_second;
      logic       pair_full;
      logic       record_end;
      logic       run_last;
   } rsp_word_type;

   // One hex digit in upper case ASCII
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) res = CHAR_0 + {4'b0, nib};
      else             res = CHAR_A + {4'b0, nib} - 8'd10;
      return res;
   endfunction

   // Two hex digits of one byte, high digit first
   function automatic logic [15:0] hex_pair(input logic [7:0] b);
      return {hex_char(b[7:4]), hex_char(b[3:0])};
   endfunction

   // Bytes of the S0 header after the type pair: count, address, text
   function automatic logic [7:0] header_byte(input logic [3:0] idx);
      logic [7:0] res;
      unique case (idx)
         4'd0:    res = 8'h0F;
         4'd1:    res = 8'h00;
         4'd2:    res = 8'h00;
         4'd3:    res = 8'h63;
         4'd4:    res = 8'h6F;
         4'd5:    res = 8'h73;
         4'd6:    res = 8'h6D;
         4'd7:    res = 8'h69;
         4'd8:    res = 8'h6E;
         4'd9:    res = 8'h2D;
         4'd10:   res = 8'h65;
         4'd11:   res = 8'h74;
         4'd12:   res = 8'h68;
         4'd13:   res = 8'h61;
         4'd14:   res = 8'h6E;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

[src/srhe_ram.sv]
module srhe_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[src/srecord_hex_encoder_unit.sv]
// The first result word is registered in the output word register once the accepted word
//   that closes a line or ends the stream has moved the state register out of idle; the output
//   sequencer then gives one result word per cycle while rsp_ready is high. Data words are taken
//   only while it is idle: a full line of LINE_BYTES holds input while its S1 record (and the S0
//   header once per stream) is sent; end of stream holds it until any pending records, S5 and S9 are sent.
// Reset clears all counters and flags; the line buffer RAM is not cleared.
module srecord_hex_encoder_unit #(
   parameter int LINE_BYTES = srhe_pkg::LINE_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srhe_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srhe_pkg::rsp_word_type rsp_data
);

   localparam int ADDR_W = $clog2(srhe_pkg::LINE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR,
      ST_S1_TYPE,
      ST_S1_CNT,
      ST_S1_AHI,
      ST_S1_ALO,
      ST_S1_DATA,
      ST_S1_SUM,
      ST_S1_NL,
      ST_S5,
      ST_S9
   } state_type;

   state_type                     state_ff, state_in;
   logic [srhe_pkg::FILL_W-1:0]   idx_ff, idx_in;
   logic [srhe_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [15:0]                   addr_ff, addr_in;
   logic [15:0]                   total_ff, total_in;
   logic [7:0]                    sum_ff, sum_in;
   logic                          hdr_sent_ff, hdr_sent_in;
   logic                          eos_ff, eos_in;
   logic                          rsp_valid_ff;
   srhe_pkg::rsp_word_type        rsp_data_ff, pair;

   logic                          req_fire;
   logic                          out_free;
   logic                          step;
   logic [7:0]                    ram_rd_data;
   logic [7:0]                    s1_cnt;
   logic [7:0]                    s1_sum;
   logic [7:0]                    s5_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = (state_ff != ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checksums of the variable records
   assign s1_cnt = {3'b0, fill_ff} + srhe_pkg::S1_EXTRA;
   assign s1_sum = ~(s1_cnt + addr_ff[15:8] + addr_ff[7:0] + sum_ff);
   assign s5_sum = ~(srhe_pkg::S5_COUNT + total_ff[15:8] + total_ff[7:0]);

   // line buffer: written on data words, read one index ahead of the sequencer
   srhe_ram #(
      .WIDTH (8),
      .DEPTH (srhe_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_fire && !req_data.func),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_data.data_byte),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // sequencer: next state and the pair for the current position
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      fill_in     = fill_ff;
      addr_in     = addr_ff;
      total_in    = total_ff;
      sum_in      = sum_ff;
      hdr_sent_in = hdr_sent_ff;
      eos_in      = eos_ff;
      pair        = '0;
      pair.pair_full = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            pair.pair_full = 1'b0;
            idx_in = '0;
            if (req_fire) begin
               if (!req_data.func) begin
                  fill_in = fill_ff + 5'd1;
                  sum_in  = sum_ff + req_data.data_byte;
                  if (fill_in == 5'(LINE_BYTES)) begin
                     state_in = hdr_sent_ff ? ST_S1_TYPE : ST_HDR;
                  end
               end else begin
                  eos_in = 1'b1;
                  if (!hdr_sent_ff)         state_in = ST_HDR;
                  else if (fill_ff != '0)   state_in = ST_S1_TYPE;
                  else                      state_in = ST_S5;
               end
            end
         end

         ST_HDR: begin
            priority if (idx_ff == '0) begin
               {pair.char_first, pair.char_second} = {srhe_pkg::CHAR_S, srhe_pkg::CHAR_0};
            end else if (idx_ff == srhe_pkg::HDR_SUM_POS) begin
               {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(srhe_pkg::HDR_SUM);
            end else if (idx_ff == srhe_pkg::HDR_NL_POS) begin
               pair.char_first = srhe_pkg::CHAR_NL;
               pair.pair_full  = 1'b0;
               pair.record_end = 1'b1;
            end else begin
               {pair.char_first, pair.char_second} =
                  srhe_pkg::hex_pair(srhe_pkg::header_byte(4'(idx_ff - 5'd1)));
            end
            if (step) begin
               if (idx_ff == srhe_pkg::HDR_NL_POS) begin
                  hdr_sent_in = 1'b1;
                  idx_in      = '0;
                  state_in    = (fill_ff != '0) ? ST_S1_TYPE : ST_S5;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end

         ST_S1_TYPE: begin
            {pair.char_first, pair.char_second} = {srhe_pkg::CHAR_S, srhe_pkg::CHAR_1};
            if (step) state_in = ST_S1_CNT;
         end

         ST_S1_CNT: begin
            {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(s1_cnt);
            if (step) state_in = ST_S1_AHI;
         end

         ST_S1_AHI: begin
            {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(addr_ff[15:8]);
            if (step) state_in = ST_S1_ALO;
         end

         ST_S1_ALO: begin
            {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(addr_ff[7:0]);
            idx_in = '0;
            if (step) state_in = ST_S1_DATA;
         end

         ST_S1_DATA: begin
            {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(ram_rd_data);
            if (step) begin
               if (idx_ff == fill_ff - 5'd1) begin
                  idx_in   = '0;
                  state_in = ST_S1_SUM;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end

         ST_S1_SUM: begin
            {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(s1_sum);
            if (step) state_in = ST_S1_NL;
         end

         ST_S1_NL: begin
            pair.char_first = srhe_pkg::CHAR_NL;
            pair.pair_full  = 1'b0;
            pair.record_end = 1'b1;
            pair.run_last   = !eos_ff;
            if (step) begin
               addr_in  = addr_ff + {11'b0, fill_ff};
               total_in = total_ff + 16'd1;
               fill_in  = '0;
               sum_in   = '0;
               idx_in   = '0;
               state_in = eos_ff ? ST_S5 : ST_IDLE;
            end
         end

         ST_S5: begin
            unique case (idx_ff)
               5'd0: {pair.char_first, pair.char_second} = {srhe_pkg::CHAR_S, srhe_pkg::CHAR_5};
               5'd1: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(srhe_pkg::S5_COUNT);
               5'd2: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(total_ff[15:8]);
               5'd3: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(total_ff[7:0]);
               5'd4: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(s5_sum);
               default: begin
                  pair.char_first = srhe_pkg::CHAR_NL;
                  pair.pair_full  = 1'b0;
                  pair.record_end = 1'b1;
               end
            endcase
            if (step) begin
               if (idx_ff == srhe_pkg::S5_NL_POS) begin
                  idx_in   = '0;
                  state_in = ST_S9;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end

         ST_S9: begin
            unique case (idx_ff)
               5'd0: {pair.char_first, pair.char_second} = {srhe_pkg::CHAR_S, srhe_pkg::CHAR_9};
               5'd1: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(srhe_pkg::S9_COUNT);
               5'd2, 5'd3: {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(8'h00);
               default: begin
                  {pair.char_first, pair.char_second} = srhe_pkg::hex_pair(srhe_pkg::S9_SUM);
                  pair.record_end = 1'b1;
                  pair.run_last   = 1'b1;
               end
            endcase
            if (step) begin
               if (idx_ff == srhe_pkg::S9_LAST_POS) begin
                  idx_in      = '0;
                  fill_in     = '0;
                  sum_in      = '0;
                  addr_in     = '0;
                  total_in    = '0;
                  hdr_sent_in = 1'b0;
                  eos_in      = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, counters and the output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         fill_ff      <= '0;
         addr_ff      <= '0;
         total_ff     <= '0;
         sum_ff       <= '0;
         hdr_sent_ff  <= 1'b0;
         eos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         fill_ff     <= fill_in;
         addr_ff     <= addr_in;
         total_ff    <= total_in;
         sum_ff      <= sum_in;
         hdr_sent_ff <= hdr_sent_in;
         eos_ff      <= eos_in;
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         rsp_data_ff <= pair;
      end
   end

endmodule
